// ===== hdl/ifb_pkg.sv =====
// ----------------------------------------------------------------------------
// ifb_pkg
// Shared types and constants of the information frame builder.
// ----------------------------------------------------------------------------
package ifb_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int PAW    = 5;

    typedef enum logic [2:0] {
        REG_FLAG   = 3'd0,
        REG_ESC    = 3'd1,
        REG_FCODE  = 3'd2,
        REG_ECODE  = 3'd3,
        REG_ADDR   = 3'd4,
        REG_CEVEN  = 3'd5,
        REG_CODD   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] flag_code;
        logic [7:0] escape_code;
        logic [7:0] frame_address;
        logic [7:0] control_even;
        logic [7:0] control_odd;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] check;
        logic       first;
        logic       seq;
        logic       last;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== hdl/info_frame_builder_top.sv =====
// ----------------------------------------------------------------------------
// info_frame_builder_top
// Byte-stuffing framer for information frames with an APB register port.
// ----------------------------------------------------------------------------
// Each pushed payload byte yields one to nine line bytes, taken from the
// output register one per cycle while pop is held: the first byte of a
// frame adds flag, address, control and header check; a flag or escape
// byte in the payload or check is sent as an escape pair; the last byte
// adds the check and the closing flag. The back sequencer loads one line
// byte per cycle while the queue holds a request and the output register
// is free or popped; a four-entry queue lets pushes continue while the
// sequencer works through earlier requests.
module info_frame_builder_top
    import ifb_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  logic [7:0]     i_payload_byte,
    input  logic           i_seq_bit,
    input  logic           i_last_byte,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     o_line_byte,
    output logic           o_last_of_item,
    output logic           o_frame_end,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    t_cfg     r_cfg;
    t_qstat   qstat;
    t_desc    enq_desc;
    t_desc    head;
    logic     enq;
    logic     deq;
    logic     wr_en;
    t_reg_idx idx;
    logic [7:0] rd_byte;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[PAW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte     <= 8'd126;
            r_cfg.escape_byte   <= 8'd125;
            r_cfg.flag_code     <= 8'd94;
            r_cfg.escape_code   <= 8'd93;
            r_cfg.frame_address <= 8'd3;
            r_cfg.control_even  <= 8'd0;
            r_cfg.control_odd   <= 8'd64;
        end else if (wr_en) begin
            case (idx)
                REG_FLAG:  r_cfg.flag_byte     <= pwdata[7:0];
                REG_ESC:   r_cfg.escape_byte   <= pwdata[7:0];
                REG_FCODE: r_cfg.flag_code     <= pwdata[7:0];
                REG_ECODE: r_cfg.escape_code   <= pwdata[7:0];
                REG_ADDR:  r_cfg.frame_address <= pwdata[7:0];
                REG_CEVEN: r_cfg.control_even  <= pwdata[7:0];
                REG_CODD:  r_cfg.control_odd   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_FLAG:  rd_byte = r_cfg.flag_byte;
            REG_ESC:   rd_byte = r_cfg.escape_byte;
            REG_FCODE: rd_byte = r_cfg.flag_code;
            REG_ECODE: rd_byte = r_cfg.escape_code;
            REG_ADDR:  rd_byte = r_cfg.frame_address;
            REG_CEVEN: rd_byte = r_cfg.control_even;
            REG_CODD:  rd_byte = r_cfg.control_odd;
            default:   rd_byte = 8'd0;
        endcase
    end

    assign prdata = {24'd0, rd_byte};
    assign full   = qstat.full;

    ifb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_payload_byte (i_payload_byte),
        .i_seq_bit      (i_seq_bit),
        .i_last_byte    (i_last_byte),
        .i_qstat        (qstat),
        .o_enq          (enq),
        .o_desc         (enq_desc)
    );

    ifb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (enq),
        .i_desc  (enq_desc),
        .i_deq   (deq),
        .o_head  (head),
        .o_qstat (qstat)
    );

    ifb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (head),
        .i_qstat        (qstat),
        .o_deq          (deq),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_line_byte    (o_line_byte),
        .o_last_of_item (o_last_of_item),
        .o_frame_end    (o_frame_end)
    );

endmodule

// ===== hdl/ifb_front.sv =====
// ----------------------------------------------------------------------------
// ifb_front
// Accepts payload requests, tracks frame state and running XOR check, and
// hands a descriptor of each request to the queue.
// ----------------------------------------------------------------------------
module ifb_front
    import ifb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_payload_byte,
    input  logic       i_seq_bit,
    input  logic       i_last_byte,
    input  t_qstat     i_qstat,
    output logic       o_enq,
    output t_desc      o_desc
);

    logic       r_in_frame;
    logic [7:0] r_check;
    logic       n_in_frame;
    logic [7:0] n_check;
    logic [7:0] chk;

    assign o_enq = i_push && !i_qstat.full;
    assign chk   = r_in_frame ? (r_check ^ i_payload_byte) : i_payload_byte;

    always_comb begin
        n_in_frame = r_in_frame;
        n_check    = r_check;
        if (o_enq) begin
            n_in_frame = !i_last_byte;
            n_check    = i_last_byte ? 8'd0 : chk;
        end
    end

    assign o_desc.data  = i_payload_byte;
    assign o_desc.check = chk;
    assign o_desc.first = !r_in_frame;
    assign o_desc.seq   = i_seq_bit;
    assign o_desc.last  = i_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_check    <= 8'd0;
        end else begin
            r_in_frame <= n_in_frame;
            r_check    <= n_check;
        end
    end

endmodule

// ===== hdl/ifb_queue.sv =====
// ----------------------------------------------------------------------------
// ifb_queue
// Short descriptor queue between the front and back parts.
// ----------------------------------------------------------------------------
module ifb_queue
    import ifb_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_enq,
    input  t_desc  i_desc,
    input  logic   i_deq,
    output t_desc  o_head,
    output t_qstat o_qstat
);

    t_desc            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW:0]     r_cnt;
    logic [QAW:0]     n_cnt;

    assign o_head        = r_mem[r_rd];
    assign o_qstat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_comb begin
        n_cnt = r_cnt;
        if (i_enq && !i_deq) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_enq && i_deq) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_enq) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_deq) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hdl/ifb_back.sv =====
// ----------------------------------------------------------------------------
// ifb_back
// Walks each descriptor through header (first byte only), stuffed payload, stuffed check and
// closing flag (last byte only), one line byte per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module ifb_back
    import ifb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_desc      i_head,
    input  t_qstat     i_qstat,
    output logic       o_deq,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_line_byte,
    output logic       o_last_of_item,
    output logic       o_frame_end
);

    typedef enum logic [8:0] {
        S_FLAG  = 9'b000000001,
        S_ADDR  = 9'b000000010,
        S_CTRL  = 9'b000000100,
        S_HCHK  = 9'b000001000,
        S_DATA  = 9'b000010000,
        S_DATA2 = 9'b000100000,
        S_CHK   = 9'b001000000,
        S_CHK2  = 9'b010000000,
        S_END   = 9'b100000000
    } t_step;

    t_step      r_step;
    logic       r_busy;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_end;

    t_step      eff;
    t_step      nxt;
    logic [7:0] sel_byte;
    logic       done;
    logic       fend;
    logic       load;
    logic [7:0] ctrl;
    logic       stuff_d;
    logic       stuff_c;
    logic [7:0] code_d;
    logic [7:0] code_c;

    assign ctrl    = i_head.seq ? i_cfg.control_odd : i_cfg.control_even;
    assign stuff_d = (i_head.data == i_cfg.flag_byte) || (i_head.data == i_cfg.escape_byte);
    assign stuff_c = (i_head.check == i_cfg.flag_byte) ||
                     (i_head.check == i_cfg.escape_byte);
    assign code_d  = (i_head.data == i_cfg.flag_byte) ? i_cfg.flag_code : i_cfg.escape_code;
    assign code_c  = (i_head.check == i_cfg.flag_byte) ? i_cfg.flag_code : i_cfg.escape_code;

    assign eff  = r_busy ? r_step : (i_head.first ? S_FLAG : S_DATA);
    assign load = !i_qstat.empty && (!r_valid || i_pop);

    always_comb begin
        sel_byte = i_cfg.flag_byte;
        nxt      = S_FLAG;
        done     = 1'b0;
        fend     = 1'b0;
        case (eff)
            S_FLAG: begin
                sel_byte = i_cfg.flag_byte;
                nxt      = S_ADDR;
            end
            S_ADDR: begin
                sel_byte = i_cfg.frame_address;
                nxt      = S_CTRL;
            end
            S_CTRL: begin
                sel_byte = ctrl;
                nxt      = S_HCHK;
            end
            S_HCHK: begin
                sel_byte = i_cfg.frame_address ^ ctrl;
                nxt      = S_DATA;
            end
            S_DATA: begin
                sel_byte = stuff_d ? i_cfg.escape_byte : i_head.data;
                if (stuff_d) begin
                    nxt = S_DATA2;
                end else if (i_head.last) begin
                    nxt = S_CHK;
                end else begin
                    done = 1'b1;
                end
            end
            S_DATA2: begin
                sel_byte = code_d;
                if (i_head.last) begin
                    nxt = S_CHK;
                end else begin
                    done = 1'b1;
                end
            end
            S_CHK: begin
                sel_byte = stuff_c ? i_cfg.escape_byte : i_head.check;
                nxt      = stuff_c ? S_CHK2 : S_END;
            end
            S_CHK2: begin
                sel_byte = code_c;
                nxt      = S_END;
            end
            S_END: begin
                sel_byte = i_cfg.flag_byte;
                done     = 1'b1;
                fend     = 1'b1;
            end
            default: begin
                sel_byte = i_cfg.flag_byte;
                nxt      = S_FLAG;
            end
        endcase
    end

    assign o_deq = load && done;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_last <= done;
            r_end  <= fend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_step  <= S_FLAG;
        end else if (load) begin
            r_valid <= 1'b1;
            r_busy  <= !done;
            r_step  <= nxt;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_empty        = !r_valid;
    assign o_line_byte    = r_byte;
    assign o_last_of_item = r_last;
    assign o_frame_end    = r_end;

endmodule

// ===== hdl/ifb_checker.sv =====
// ----------------------------------------------------------------------------
// ifb_checker
// Port-level checks of the information frame builder, bound to the top.
// ----------------------------------------------------------------------------
module ifb_checker
    import ifb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_line_byte,
    input logic       o_last_of_item,
    input logic       o_frame_end,
    input logic       pready
);

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end) |-> o_last_of_item)
        else $error("closing flag not marked last of request");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not cleared by reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_line_byte) && $stable(o_frame_end)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

endmodule

bind info_frame_builder_top ifb_checker u_ifb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_line_byte    (o_line_byte),
    .o_last_of_item (o_last_of_item),
    .o_frame_end    (o_frame_end),
    .pready         (pready)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - information frame builder
// Pushes payload bytes in whole frames under several register settings and
// pops the framed line bytes with random gaps on the push and pop sides. Every popped
// byte is compared with a framer model kept in a scoreboard.
// ----------------------------------------------------------------------------
module testbench;
    import ifb_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 20;
    localparam int RESET_LEN   = 6;
    localparam int UNUSED_REG  = 7;

    logic           i_clk;
    logic           i_rst_n;
    logic           push;
    logic           full;
    logic [7:0]     i_payload_byte;
    logic           i_seq_bit;
    logic           i_last_byte;
    logic           empty;
    logic           pop;
    logic [7:0]     o_line_byte;
    logic           o_last_of_item;
    logic           o_frame_end;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [PAW-1:0] paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    int cycles = 0;
    bit tx_calm;
    bit rx_calm;

    typedef struct packed {
        logic [7:0] line;
        logic       last_of_item;
        logic       frame_end;
    } t_line;

    class frame_scoreboard;
        logic [7:0] regs [0:6];
        bit         in_frame;
        logic [7:0] check;
        t_line      line_q[$];
        int         errors;

        function new();
            regs[REG_FLAG]  = 8'd126;
            regs[REG_ESC]   = 8'd125;
            regs[REG_FCODE] = 8'd94;
            regs[REG_ECODE] = 8'd93;
            regs[REG_ADDR]  = 8'd3;
            regs[REG_CEVEN] = 8'd0;
            regs[REG_CODD]  = 8'd64;
            in_frame = 0;
            check = 8'd0;
            errors = 0;
        endfunction

        function void set_reg(int idx, logic [7:0] v);
            if (idx <= int'(REG_CODD)) begin
                regs[idx] = v;
            end
        endfunction

        function void add_line(ref t_line lines[$], input logic [7:0] b, input logic fe);
            t_line l;
            l.line = b;
            l.last_of_item = 1'b0;
            l.frame_end = fe;
            lines.push_back(l);
        endfunction

        function void add_stuffed(ref t_line lines[$], input logic [7:0] b);
            if (b == regs[REG_FLAG]) begin
                add_line(lines, regs[REG_ESC], 1'b0);
                add_line(lines, regs[REG_FCODE], 1'b0);
            end else if (b == regs[REG_ESC]) begin
                add_line(lines, regs[REG_ESC], 1'b0);
                add_line(lines, regs[REG_ECODE], 1'b0);
            end else begin
                add_line(lines, b, 1'b0);
            end
        endfunction

        // Accepted request: expand to the line bytes it produces.
        function void note_request(logic [7:0] data, logic seq, logic last);
            t_line      lines[$];
            logic [7:0] ctrl;
            if (!in_frame) begin
                ctrl = seq ? regs[REG_CODD] : regs[REG_CEVEN];
                add_line(lines, regs[REG_FLAG], 1'b0);
                add_line(lines, regs[REG_ADDR], 1'b0);
                add_line(lines, ctrl, 1'b0);
                add_line(lines, regs[REG_ADDR] ^ ctrl, 1'b0);
                check = 8'd0;
                in_frame = 1;
            end
            check = check ^ data;
            add_stuffed(lines, data);
            if (last) begin
                add_stuffed(lines, check);
                add_line(lines, regs[REG_FLAG], 1'b1);
                in_frame = 0;
                check = 8'd0;
            end
            lines[lines.size() - 1].last_of_item = 1'b1;
            foreach (lines[i]) line_q.push_back(lines[i]);
        endfunction

        function void check_line(logic [7:0] b, logic loi, logic fe);
            t_line want;
            t_line got;
            got.line = b;
            got.last_of_item = loi;
            got.frame_end = fe;
            if (line_q.size() == 0) begin
                $display("%0t: unexpected line byte %h last_of_item %b frame_end %b",
                         $time, b, loi, fe);
                errors++;
            end else begin
                want = line_q.pop_front();
                if (got !== want) begin
                    $display("%0t: expected byte %h loi %b end %b, got byte %h loi %b end %b",
                             $time, want.line, want.last_of_item, want.frame_end,
                             b, loi, fe);
                    errors++;
                end
            end
        endfunction

        function int waiting();
            return line_q.size();
        endfunction
    endclass

    frame_scoreboard sb;

    info_frame_builder_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_payload_byte (i_payload_byte),
        .i_seq_bit      (i_seq_bit),
        .i_last_byte    (i_last_byte),
        .empty          (empty),
        .pop            (pop),
        .o_line_byte    (o_line_byte),
        .o_last_of_item (o_last_of_item),
        .o_frame_end    (o_frame_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int gap_len(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Payload bytes biased toward the flag, escape and code register values.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return sb.regs[REG_FLAG];
            1: return sb.regs[REG_ESC];
            2: return sb.regs[REG_FCODE];
            3: return sb.regs[REG_ECODE];
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic s, input logic l);
        int g;
        @(negedge i_clk);
        push <= 1'b1;
        i_payload_byte <= d;
        i_seq_bit <= s;
        i_last_byte <= l;
        do @(posedge i_clk); while (full);
        sb.note_request(d, s, l);
        g = gap_len(tx_calm);
        if (g > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.waiting() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input logic [7:0] v);
        logic [31:0] word;
        word = $urandom;
        word[7:0] = v;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PAW'(idx * 4);
        pwdata <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_all(input logic [7:0] v);
        for (int i = 0; i <= int'(REG_CODD); i++) write_reg(i, v);
    endtask

    task automatic random_config();
        logic [7:0] v [0:6];
        foreach (v[i]) v[i] = 8'($urandom);
        case ($urandom_range(0, 5))
            0: v[REG_ESC] = v[REG_FLAG];
            1: v[REG_ADDR] = v[REG_FLAG];
            2: v[REG_CEVEN] = v[REG_ESC];
            default: ;
        endcase
        foreach (v[i]) write_reg(i, v[i]);
    endtask

    task automatic run_frames(input int n_items);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 50) len = $urandom_range(1, 3);
            else if (r < 90) len = $urandom_range(4, 8);
            else len = $urandom_range(9, 20);
            for (int i = 0; i < len; i++) begin
                send_byte(pick_byte(), 1'($urandom), i == len - 1);
            end
            sent += len;
        end
    endtask

    // Receiver: random pop stalls, results checked at the rising edge.
    initial begin
        int stall;
        stall = 0;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
                stall = gap_len(rx_calm);
            end
            @(posedge i_clk);
            if (pop && !empty) sb.check_line(o_line_byte, o_last_of_item, o_frame_end);
        end
    end

    initial begin
        sb = new();
        tx_calm = 0;
        rx_calm = 0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_payload_byte = 8'd0;
        i_seq_bit = 1'b0;
        i_last_byte = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = 32'd0;
        repeat (RESET_LEN) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: single-byte frames, stuffed payload and check
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h7E, 1'b1, 1'b1);
        send_byte(8'h7D, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        // seq bit changes mid-frame are ignored
        send_byte(8'h7E, 1'b1, 1'b0);
        send_byte(8'h7D, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'h03, 1'b1, 1'b1);
        // check equal to flag, then to escape
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(8'h6C, 1'b1, 1'b1);
        send_byte(8'h10, 1'b1, 1'b0);
        send_byte(8'h6D, 1'b0, 1'b1);
        send_byte(8'h5E, 1'b0, 1'b0);
        send_byte(8'h5D, 1'b1, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        drain();

        // flag equal to escape, header bytes colliding with it
        write_reg(REG_FLAG, 8'h55);
        write_reg(REG_ESC, 8'h55);
        write_reg(REG_FCODE, 8'h01);
        write_reg(REG_ECODE, 8'h02);
        write_reg(REG_ADDR, 8'h55);
        write_reg(REG_CEVEN, 8'h55);
        write_reg(REG_CODD, 8'hAA);
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'h55, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        drain();

        write_all(8'h00);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        drain();

        write_all(8'hFF);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b1);
        drain();

        // unmapped register: write must have no effect
        write_reg(UNUSED_REG, 8'h3C);
        send_byte(8'h3C, 1'b0, 1'b1);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            tx_calm = (phase == 2);
            rx_calm = (phase == 2);
            random_config();
            run_frames(26);
            if (phase == 3) drain();
            run_frames(26);
            drain();
        end

        if (sb.waiting() > 0) begin
            $display("%0t: %0d line bytes never arrived", $time, sb.waiting());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ifb_pkg.sv
hdl/ifb_front.sv
hdl/ifb_queue.sv
hdl/ifb_back.sv
hdl/info_frame_builder_top.sv
hdl/ifb_checker.sv
tb/testbench.sv
